FILE: sv/sofla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofla_pkg: shared types and constants of the free-list allocator
// Field widths, tag constants, status and opcode values, and the state
// encoding of the request sequencer.
// ----------------------------------------------------------------------------
package sofla_pkg;

   // Default heap capacity in bytes
   localparam int HEAP_BYTES_DEF = 1048576;

   // Transaction field widths
   localparam int OP_W     = 1;
   localparam int REQ_W    = 21;
   localparam int OFF_W    = 20;
   localparam int CHUNK_W  = 21;
   localparam int STATUS_W = 2;

   // Minimum width of internal byte arithmetic (padded request plus headroom)
   localparam int MIN_XW = REQ_W + 2;

   // Reset value of the heap growth register
   localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(4096);

   // Tag layout
   localparam int WORD_BYTES   = 4;
   localparam int DWORD_BYTES  = 8;
   localparam int MIN_BLOCK    = 16;
   localparam int REQ_PAD      = 15;
   localparam int ALIGN_MASK   = 7;
   localparam int HEAP_START   = 16;
   localparam int PROLOGUE_HDR = 4;
   localparam int PROLOGUE_FTR = 8;
   localparam int EPILOGUE_HDR = 12;
   localparam logic [31:0] TAG_ALLOC    = 32'h1;
   localparam logic [31:0] PROLOGUE_TAG = 32'h9;

   // Request kinds
   localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
   localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

   // Request and result payloads
   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [REQ_W-1:0] request_size;
      logic [OFF_W-1:0] block_offset;
   } req_type;

   typedef struct packed {
      logic [OFF_W-1:0]    result_offset;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // Sequencer states
   typedef enum logic [5:0] {
      S_IDLE, S_DISPATCH,
      S_INIT0, S_INIT1, S_INIT2, S_INIT3,
      S_GROW0, S_GROW1, S_GROW2,
      S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
      S_MA1, S_MA2, S_MA3,
      S_MB1, S_MB2, S_MB3, S_MB4,
      S_MC1, S_MC2, S_MC3, S_MC4, S_MC5,
      S_R0, S_R1, S_R2, S_R3, S_R4, S_R5, S_R6,
      S_I0, S_I1, S_I2, S_I3, S_I4, S_I5, S_I6, S_I7, S_I8,
      S_ACHECK, S_BF0, S_BF1, S_BF2, S_AGROWN,
      S_TK0, S_TK1, S_TK2, S_TK3, S_TK4, S_TK5, S_TK6,
      S_F0, S_F1, S_F2, S_F3,
      S_FIN
   } state_type;

endpackage

FILE: sv/sofla_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofla_ifs: channel interfaces of the free-list allocator
// Request, response and register-write channels, each with valid/ready.
// ----------------------------------------------------------------------------

// Request channel
interface sofla_req_if;
   import sofla_pkg::*;
   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  op;
   logic [REQ_W-1:0] request_size;
   logic [OFF_W-1:0] block_offset;
   modport source (output valid, output op, output request_size, output block_offset,
                   input ready);
   modport sink   (input valid, input op, input request_size, input block_offset,
                   output ready);
endinterface

// Response channel
interface sofla_rsp_if;
   import sofla_pkg::*;
   logic                valid;
   logic                ready;
   logic [OFF_W-1:0]    result_offset;
   logic [STATUS_W-1:0] status;
   modport source (output valid, output result_offset, output status, input ready);
   modport sink   (input valid, input result_offset, input status, output ready);
endinterface

// Register write channel (growth size)
interface sofla_csr_if;
   import sofla_pkg::*;
   logic               valid;
   logic               ready;
   logic [CHUNK_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/sofla_heap_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofla_heap_ram: heap word store
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module sofla_heap_ram #(
   parameter  int DEPTH = sofla_pkg::HEAP_BYTES_DEF / 4,
   localparam int IW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          we,
   input  logic [IW-1:0] waddr,
   input  logic [31:0]   wdata,
   input  logic          re,
   input  logic [IW-1:0] raddr,
   output logic [31:0]   rdata
);

   logic [31:0] mem_ff [DEPTH];
   logic [31:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/sofla_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofla_engine: request sequencer
// Walks the size-ordered free list and reads/writes boundary tags and links
// in the heap RAM, at most one access per cycle. Merge, list insert/remove and heap
// growth are shared routines entered with a return state.
// ----------------------------------------------------------------------------
module sofla_engine #(
   parameter  int HEAP_BYTES = sofla_pkg::HEAP_BYTES_DEF,
   localparam int AW = $clog2(HEAP_BYTES) + 1,
   localparam int XW = (AW + 1 > sofla_pkg::MIN_XW) ? AW + 1 : sofla_pkg::MIN_XW,
   localparam int IW = $clog2(HEAP_BYTES / 4)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  sofla_pkg::req_type            cmd,
   input  logic [sofla_pkg::CHUNK_W-1:0] chunk,
   input  logic                          out_free,
   output logic                          idle,
   output logic                          done,
   output sofla_pkg::rsp_type            rsp,
   output logic                          ram_we,
   output logic [IW-1:0]                 ram_waddr,
   output logic [31:0]                   ram_wdata,
   output logic                          ram_re,
   output logic [IW-1:0]                 ram_raddr,
   input  logic [31:0]                   ram_rdata
);
   import sofla_pkg::*;

   localparam int WALK_LIMIT = HEAP_BYTES / 16 + 1;
   localparam int SW = $clog2(WALK_LIMIT + 1);
   localparam logic [XW-1:0] X_WORD  = XW'(WORD_BYTES);
   localparam logic [XW-1:0] X_DWORD = XW'(DWORD_BYTES);
   localparam logic [XW-1:0] X_MIN   = XW'(MIN_BLOCK);
   localparam logic [XW-1:0] X_HEAP  = XW'(HEAP_BYTES);

   // control state
   state_type state_ff, state_in;
   state_type init_ret_ff, init_ret_in;
   state_type grow_ret_ff, grow_ret_in;
   state_type merge_ret_ff, merge_ret_in;
   state_type rem_ret_ff, rem_ret_in;
   logic          ready_ff, ready_in;
   logic [XW-1:0] brk_ff, brk_in;
   logic [XW-1:0] flist_ff, flist_in;

   // working registers
   logic [OP_W-1:0]     op_ff, op_in;
   logic [REQ_W-1:0]    req_ff, req_in;
   logic [XW-1:0]       off_ff, off_in;
   logic [XW-1:0]       asize_ff, asize_in;
   logic [XW-1:0]       gsize_ff, gsize_in;
   logic [XW-1:0]       bp_ff, bp_in;
   logic [XW-1:0]       size_ff, size_in;
   logic [XW-1:0]       prev_ff, prev_in;
   logic [XW-1:0]       next_ff, next_in;
   logic [XW-1:0]       nsz_ff, nsz_in;
   logic                pa_ff, pa_in;
   logic [XW-1:0]       rx_ff, rx_in;
   logic [XW-1:0]       rp_ff, rp_in;
   logic [XW-1:0]       rs_ff, rs_in;
   logic [XW-1:0]       want_ff, want_in;
   logic [XW-1:0]       cur_ff, cur_in;
   logic [XW-1:0]       before_ff, before_in;
   logic [SW-1:0]       steps_ff, steps_in;
   logic [XW-1:0]       tbp_ff, tbp_in;
   logic [XW-1:0]       csize_ff, csize_in;
   logic [31:0]         hdr_ff, hdr_in;
   logic [XW-1:0]       res_ff, res_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                rd_oob_ff;

   // byte-addressed access request
   logic          mem_we, mem_re;
   logic [XW-1:0] mem_waddr, mem_raddr;
   logic [31:0]   mem_wdata;

   // decoded read word
   logic [31:0]   rword;
   logic [XW-1:0] tsz, rlink, fsize;
   logic          ralloc;

   // sizes derived from the request and the growth register
   logic [CHUNK_W:0] chunk_rnd;
   logic [REQ_W:0]   req_rnd;
   logic [XW-1:0]    chunk_sz, asize_calc, grow_end;
   logic             free_bad;

   // words beyond the heap read as zero
   assign rword  = rd_oob_ff ? 32'h0 : ram_rdata;
   assign tsz    = {rword[XW-1:3], 3'b000};
   assign rlink  = rword[XW-1:0];
   assign ralloc = rword[0];
   assign fsize  = {hdr_ff[XW-1:3], 3'b000};

   always_comb begin
      chunk_rnd = ({1'b0, chunk} + (CHUNK_W + 1)'(ALIGN_MASK)) & ~(CHUNK_W + 1)'(ALIGN_MASK);
      chunk_sz  = (XW'(chunk_rnd) < X_MIN) ? X_MIN : XW'(chunk_rnd);
      req_rnd   = ({1'b0, req_ff} + (REQ_W + 1)'(REQ_PAD)) & ~(REQ_W + 1)'(ALIGN_MASK);
      asize_calc = (req_ff < REQ_W'(DWORD_BYTES)) ? X_MIN : XW'(req_rnd);
      grow_end  = brk_ff + gsize_ff;
      free_bad  = (off_ff[2:0] != 3'b000) || (off_ff < XW'(HEAP_START)) ||
                  (off_ff >= brk_ff) || !hdr_ff[0] || (fsize < X_MIN) ||
                  (off_ff + fsize > brk_ff) || (rword != hdr_ff);
   end

   // RAM port mapping, out-of-range writes dropped
   assign ram_we    = mem_we && (mem_waddr < X_HEAP);
   assign ram_waddr = mem_waddr[IW+1:2];
   assign ram_wdata = mem_wdata;
   assign ram_re    = mem_re;
   assign ram_raddr = mem_raddr[IW+1:2];

   assign idle = (state_ff == S_IDLE);
   assign rsp.result_offset = res_ff[OFF_W-1:0];
   assign rsp.status        = status_ff;

   // sequencer: at most one RAM access per state, reads never share a cycle with a write
   always_comb begin
      state_in     = state_ff;
      init_ret_in  = init_ret_ff;
      grow_ret_in  = grow_ret_ff;
      merge_ret_in = merge_ret_ff;
      rem_ret_in   = rem_ret_ff;
      ready_in     = ready_ff;
      brk_in       = brk_ff;
      flist_in     = flist_ff;
      op_in        = op_ff;
      req_in       = req_ff;
      off_in       = off_ff;
      asize_in     = asize_ff;
      gsize_in     = gsize_ff;
      bp_in        = bp_ff;
      size_in      = size_ff;
      prev_in      = prev_ff;
      next_in      = next_ff;
      nsz_in       = nsz_ff;
      pa_in        = pa_ff;
      rx_in        = rx_ff;
      rp_in        = rp_ff;
      rs_in        = rs_ff;
      want_in      = want_ff;
      cur_in       = cur_ff;
      before_in    = before_ff;
      steps_in     = steps_ff;
      tbp_in       = tbp_ff;
      csize_in     = csize_ff;
      hdr_in       = hdr_ff;
      res_in       = res_ff;
      status_in    = status_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      done         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = cmd.op;
               req_in   = cmd.request_size;
               off_in   = XW'(cmd.block_offset);
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (op_ff == OP_ALLOC) begin
               init_ret_in = S_ACHECK;
               state_in    = ready_ff ? S_ACHECK : S_INIT0;
            end else if (off_ff == '0) begin
               res_in    = '0;
               status_in = ST_IGNORED;
               state_in  = S_FIN;
            end else begin
               init_ret_in = S_F0;
               state_in    = ready_ff ? S_F0 : S_INIT0;
            end
         end

         // heap setup: pad word, prologue, epilogue, first growth
         S_INIT0: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = 32'h0;
            ready_in  = 1'b1;
            flist_in  = '0;
            brk_in    = XW'(HEAP_START);
            state_in  = S_INIT1;
         end
         S_INIT1: begin
            mem_we    = 1'b1;
            mem_waddr = XW'(PROLOGUE_HDR);
            mem_wdata = PROLOGUE_TAG;
            state_in  = S_INIT2;
         end
         S_INIT2: begin
            mem_we    = 1'b1;
            mem_waddr = XW'(PROLOGUE_FTR);
            mem_wdata = PROLOGUE_TAG;
            state_in  = S_INIT3;
         end
         S_INIT3: begin
            mem_we      = 1'b1;
            mem_waddr   = XW'(EPILOGUE_HDR);
            mem_wdata   = TAG_ALLOC;
            gsize_in    = chunk_sz;
            grow_ret_in = init_ret_ff;
            state_in    = S_GROW0;
         end

         // growth by gsize; result pointer left in bp (zero on failure)
         S_GROW0: begin
            if (grow_end > X_HEAP) begin
               bp_in    = '0;
               state_in = grow_ret_ff;
            end else begin
               bp_in     = brk_ff;
               brk_in    = grow_end;
               mem_we    = 1'b1;
               mem_waddr = brk_ff - X_WORD;
               mem_wdata = 32'(gsize_ff);
               state_in  = S_GROW1;
            end
         end
         S_GROW1: begin
            mem_we    = 1'b1;
            mem_waddr = bp_ff + gsize_ff - X_DWORD;
            mem_wdata = 32'(gsize_ff);
            state_in  = S_GROW2;
         end
         S_GROW2: begin
            mem_we       = 1'b1;
            mem_waddr    = bp_ff + gsize_ff - X_WORD;
            mem_wdata    = TAG_ALLOC;
            merge_ret_in = grow_ret_ff;
            state_in     = S_M0;
         end

         // merge: fetch own size and both neighbour tags
         S_M0: begin
            mem_re    = 1'b1;
            mem_raddr = bp_ff - X_WORD;
            state_in  = S_M1;
         end
         S_M1: begin
            size_in   = tsz;
            mem_re    = 1'b1;
            mem_raddr = bp_ff - X_DWORD;
            state_in  = S_M2;
         end
         S_M2: begin
            prev_in   = bp_ff - tsz;
            mem_re    = 1'b1;
            mem_raddr = bp_ff - tsz - X_WORD;
            state_in  = S_M3;
         end
         S_M3: begin
            mem_re    = 1'b1;
            mem_raddr = prev_ff + tsz - X_DWORD;
            state_in  = S_M4;
         end
         S_M4: begin
            pa_in     = ralloc;
            next_in   = bp_ff + size_ff;
            mem_re    = 1'b1;
            mem_raddr = bp_ff + size_ff - X_WORD;
            state_in  = S_M5;
         end
         S_M5: begin
            if (pa_ff && ralloc) begin
               state_in = S_I0;
            end else if (pa_ff) begin
               rx_in      = next_ff;
               rem_ret_in = S_MA1;
               state_in   = S_R0;
            end else if (ralloc) begin
               rx_in      = prev_ff;
               rem_ret_in = S_MB1;
               state_in   = S_R0;
            end else begin
               rx_in      = prev_ff;
               rem_ret_in = S_MC1;
               state_in   = S_R0;
            end
         end

         // next block free
         S_MA1: begin
            mem_re    = 1'b1;
            mem_raddr = next_ff - X_WORD;
            state_in  = S_MA2;
         end
         S_MA2: begin
            size_in   = size_ff + tsz;
            mem_we    = 1'b1;
            mem_waddr = bp_ff - X_WORD;
            mem_wdata = 32'(size_ff + tsz);
            state_in  = S_MA3;
         end
         S_MA3: begin
            mem_we    = 1'b1;
            mem_waddr = bp_ff + size_ff - X_DWORD;
            mem_wdata = 32'(size_ff);
            state_in  = S_I0;
         end

         // previous block free
         S_MB1: begin
            mem_re    = 1'b1;
            mem_raddr = prev_ff - X_WORD;
            state_in  = S_MB2;
         end
         S_MB2: begin
            size_in   = size_ff + tsz;
            mem_re    = 1'b1;
            mem_raddr = bp_ff - X_WORD;
            state_in  = S_MB3;
         end
         S_MB3: begin
            mem_we    = 1'b1;
            mem_waddr = bp_ff + tsz - X_DWORD;
            mem_wdata = 32'(size_ff);
            state_in  = S_MB4;
         end
         S_MB4: begin
            mem_we    = 1'b1;
            mem_waddr = prev_ff - X_WORD;
            mem_wdata = 32'(size_ff);
            bp_in     = prev_ff;
            state_in  = S_I0;
         end

         // both neighbours free
         S_MC1: begin
            rx_in      = next_ff;
            rem_ret_in = S_MC2;
            state_in   = S_R0;
         end
         S_MC2: begin
            mem_re    = 1'b1;
            mem_raddr = next_ff - X_WORD;
            state_in  = S_MC3;
         end
         S_MC3: begin
            nsz_in    = tsz;
            size_in   = size_ff + tsz;
            mem_re    = 1'b1;
            mem_raddr = prev_ff - X_WORD;
            state_in  = S_MC4;
         end
         S_MC4: begin
            size_in   = size_ff + tsz;
            mem_we    = 1'b1;
            mem_waddr = prev_ff - X_WORD;
            mem_wdata = 32'(size_ff + tsz);
            state_in  = S_MC5;
         end
         S_MC5: begin
            mem_we    = 1'b1;
            mem_waddr = next_ff + nsz_ff - X_DWORD;
            mem_wdata = 32'(size_ff);
            bp_in     = prev_ff;
            state_in  = S_I0;
         end

         // unlink rx from the free list
         S_R0: begin
            mem_re    = 1'b1;
            mem_raddr = rx_ff - X_WORD;
            state_in  = S_R1;
         end
         S_R1: begin
            if (ralloc || (flist_ff == '0)) begin
               state_in = rem_ret_ff;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = rx_ff;
               state_in  = S_R2;
            end
         end
         S_R2: begin
            rp_in     = rlink;
            mem_re    = 1'b1;
            mem_raddr = rx_ff + X_WORD;
            state_in  = S_R3;
         end
         S_R3: begin
            rs_in = rlink;
            if (rx_ff == flist_ff) begin
               flist_in = rlink;
               if (rlink != '0) begin
                  mem_we    = 1'b1;
                  mem_waddr = rlink;
                  mem_wdata = 32'h0;
               end
               state_in = S_R5;
            end else begin
               if (rp_ff != '0) begin
                  mem_we    = 1'b1;
                  mem_waddr = rp_ff + X_WORD;
                  mem_wdata = 32'(rlink);
               end
               state_in = S_R4;
            end
         end
         S_R4: begin
            if (rs_ff != '0) begin
               mem_we    = 1'b1;
               mem_waddr = rs_ff;
               mem_wdata = 32'(rp_ff);
            end
            state_in = S_R5;
         end
         S_R5: begin
            mem_we    = 1'b1;
            mem_waddr = rx_ff;
            mem_wdata = 32'h0;
            state_in  = S_R6;
         end
         S_R6: begin
            mem_we    = 1'b1;
            mem_waddr = rx_ff + X_WORD;
            mem_wdata = 32'h0;
            state_in  = rem_ret_ff;
         end

         // sorted insert of bp, then return from merge
         S_I0: begin
            mem_re    = 1'b1;
            mem_raddr = bp_ff - X_WORD;
            state_in  = S_I1;
         end
         S_I1: begin
            if (ralloc) begin
               state_in = merge_ret_ff;
            end else begin
               want_in   = tsz;
               cur_in    = flist_ff;
               before_in = '0;
               steps_in  = '0;
               state_in  = S_I2;
            end
         end
         S_I2: begin
            if ((cur_ff == '0) || (steps_ff == SW'(WALK_LIMIT))) begin
               state_in = S_I5;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = cur_ff - X_WORD;
               state_in  = S_I3;
            end
         end
         S_I3: begin
            if (tsz < want_ff) begin
               before_in = cur_ff;
               mem_re    = 1'b1;
               mem_raddr = cur_ff + X_WORD;
               state_in  = S_I4;
            end else begin
               state_in = S_I5;
            end
         end
         S_I4: begin
            cur_in   = rlink;
            steps_in = steps_ff + SW'(1);
            state_in = S_I2;
         end
         S_I5: begin
            mem_we    = 1'b1;
            mem_waddr = bp_ff;
            mem_wdata = 32'(before_ff);
            state_in  = S_I6;
         end
         S_I6: begin
            mem_we    = 1'b1;
            mem_waddr = bp_ff + X_WORD;
            mem_wdata = 32'(cur_ff);
            state_in  = S_I7;
         end
         S_I7: begin
            if (before_ff == '0) begin
               flist_in = bp_ff;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = before_ff + X_WORD;
               mem_wdata = 32'(bp_ff);
            end
            state_in = S_I8;
         end
         S_I8: begin
            if (cur_ff != '0) begin
               mem_we    = 1'b1;
               mem_waddr = cur_ff;
               mem_wdata = 32'(bp_ff);
            end
            state_in = merge_ret_ff;
         end

         // allocate: pad, best-fit walk, grow on miss
         S_ACHECK: begin
            if (req_ff == '0) begin
               res_in    = '0;
               status_in = ST_IGNORED;
               state_in  = S_FIN;
            end else begin
               asize_in = asize_calc;
               cur_in   = flist_ff;
               steps_in = '0;
               state_in = S_BF0;
            end
         end
         S_BF0: begin
            if ((cur_ff == '0) || (steps_ff == SW'(WALK_LIMIT))) begin
               gsize_in    = (asize_ff > chunk_sz) ? asize_ff : chunk_sz;
               grow_ret_in = S_AGROWN;
               state_in    = S_GROW0;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = cur_ff - X_WORD;
               state_in  = S_BF1;
            end
         end
         S_BF1: begin
            if (asize_ff <= tsz) begin
               tbp_in   = cur_ff;
               state_in = S_TK0;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = cur_ff + X_WORD;
               state_in  = S_BF2;
            end
         end
         S_BF2: begin
            cur_in   = rlink;
            steps_in = steps_ff + SW'(1);
            state_in = S_BF0;
         end
         S_AGROWN: begin
            if (bp_ff == '0) begin
               res_in    = '0;
               status_in = ST_OOM;
               state_in  = S_FIN;
            end else begin
               tbp_in   = bp_ff;
               state_in = S_TK0;
            end
         end

         // take block tbp, split off the remainder if it is at least a minimum block
         S_TK0: begin
            mem_re    = 1'b1;
            mem_raddr = tbp_ff - X_WORD;
            state_in  = S_TK1;
         end
         S_TK1: begin
            csize_in = tsz;
            if (!ralloc) begin
               rx_in      = tbp_ff;
               rem_ret_in = S_TK2;
               state_in   = S_R0;
            end else begin
               state_in = S_TK2;
            end
         end
         S_TK2: begin
            mem_we    = 1'b1;
            mem_waddr = tbp_ff - X_WORD;
            if (csize_ff >= asize_ff + X_MIN) begin
               mem_wdata = 32'(asize_ff) | TAG_ALLOC;
               state_in  = S_TK3;
            end else begin
               mem_wdata = 32'(csize_ff) | TAG_ALLOC;
               state_in  = S_TK6;
            end
         end
         S_TK3: begin
            mem_we    = 1'b1;
            mem_waddr = tbp_ff + asize_ff - X_DWORD;
            mem_wdata = 32'(asize_ff) | TAG_ALLOC;
            state_in  = S_TK4;
         end
         S_TK4: begin
            mem_we    = 1'b1;
            mem_waddr = tbp_ff + asize_ff - X_WORD;
            mem_wdata = 32'(csize_ff - asize_ff);
            state_in  = S_TK5;
         end
         S_TK5: begin
            mem_we       = 1'b1;
            mem_waddr    = tbp_ff + csize_ff - X_DWORD;
            mem_wdata    = 32'(csize_ff - asize_ff);
            bp_in        = tbp_ff + asize_ff;
            merge_ret_in = S_FIN;
            res_in       = tbp_ff;
            status_in    = ST_DONE;
            state_in     = S_M0;
         end
         S_TK6: begin
            mem_we    = 1'b1;
            mem_waddr = tbp_ff + csize_ff - X_DWORD;
            mem_wdata = 32'(csize_ff) | TAG_ALLOC;
            res_in    = tbp_ff;
            status_in = ST_DONE;
            state_in  = S_FIN;
         end

         // free: validate tags, clear allocated bit, merge
         S_F0: begin
            mem_re    = 1'b1;
            mem_raddr = off_ff - X_WORD;
            state_in  = S_F1;
         end
         S_F1: begin
            hdr_in    = rword;
            mem_re    = 1'b1;
            mem_raddr = off_ff + tsz - X_DWORD;
            state_in  = S_F2;
         end
         S_F2: begin
            if (free_bad) begin
               res_in    = '0;
               status_in = ST_IGNORED;
               state_in  = S_FIN;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = off_ff - X_WORD;
               mem_wdata = 32'(fsize);
               state_in  = S_F3;
            end
         end
         S_F3: begin
            mem_we       = 1'b1;
            mem_waddr    = off_ff + fsize - X_DWORD;
            mem_wdata    = 32'(fsize);
            bp_in        = off_ff;
            merge_ret_in = S_FIN;
            res_in       = '0;
            status_in    = ST_DONE;
            state_in     = S_M0;
         end

         // hand result to the output register
         S_FIN: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
         brk_ff   <= '0;
         flist_ff <= '0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         brk_ff   <= brk_in;
         flist_ff <= flist_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      init_ret_ff  <= init_ret_in;
      grow_ret_ff  <= grow_ret_in;
      merge_ret_ff <= merge_ret_in;
      rem_ret_ff   <= rem_ret_in;
      op_ff        <= op_in;
      req_ff       <= req_in;
      off_ff       <= off_in;
      asize_ff     <= asize_in;
      gsize_ff     <= gsize_in;
      bp_ff        <= bp_in;
      size_ff      <= size_in;
      prev_ff      <= prev_in;
      next_ff      <= next_in;
      nsz_ff       <= nsz_in;
      pa_ff        <= pa_in;
      rx_ff        <= rx_in;
      rp_ff        <= rp_in;
      rs_ff        <= rs_in;
      want_ff      <= want_in;
      cur_ff       <= cur_in;
      before_ff    <= before_in;
      steps_ff     <= steps_in;
      tbp_ff       <= tbp_in;
      csize_ff     <= csize_in;
      hdr_ff       <= hdr_in;
      res_ff       <= res_in;
      status_ff    <= status_in;
      if (mem_re) begin
         rd_oob_ff <= (mem_raddr >= X_HEAP);
      end
   end

`ifndef NO_ASSERTIONS
   // read and write never share a cycle, so no same-entry forwarding is needed
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("heap read and write issued together");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!mem_we && !mem_re))
      else $error("heap access while idle");

   a_brk_bound: assert property (@(posedge clock) disable iff (reset)
      brk_ff <= X_HEAP)
      else $error("heap break beyond capacity");

   a_brk_mono: assert property (@(posedge clock) disable iff (reset)
      ready_ff |=> (brk_ff >= $past(brk_ff)))
      else $error("heap break moved backwards");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> (state_ff == S_IDLE))
      else $error("sequencer busy after result handoff");
`endif

endmodule

FILE: sv/size_ordered_free_list_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_ordered_free_list_allocator_core: boundary-tag heap allocator
// Best-fit allocate and coalescing free over a heap RAM with a size-ordered
// explicit free list.
// ----------------------------------------------------------------------------
// Usage:
//  req_if carries one request per transaction: op (allocate or free),
//  request_size and block_offset. rsp_if returns exactly one transaction per
//  request: result_offset and status (done, out of memory, ignored).
//  csr_if writes the minimum growth size; write it only while idle.
//  Requests are handled one at a time. The time a request takes grows with
//  the free-list blocks walked in the best-fit search and in each sorted
//  insert. It is set by the single heap RAM port doing at most one tag or
//  link access per cycle with registered read data. The first request after
//  reset also sets up the heap.
//  Reset empties the heap logically (no RAM clear pass) and sets the growth
//  size to 4096 bytes. The result sits in an output register; while the
//  receiver stalls it holds, and the next request is taken once the
//  sequencer has handed its result over.
// ----------------------------------------------------------------------------
module size_ordered_free_list_allocator_core #(
   parameter int HEAP_BYTES = sofla_pkg::HEAP_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sofla_req_if.sink   req_if,
   sofla_rsp_if.source rsp_if,
   sofla_csr_if.sink   csr_if
);
   import sofla_pkg::*;

   localparam int IW = $clog2(HEAP_BYTES / 4);

   logic               start, idle, done, out_free;
   req_type            cmd;
   rsp_type            eng_rsp;
   logic [CHUNK_W-1:0] chunk_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic          ram_we, ram_re;
   logic [IW-1:0] ram_waddr, ram_raddr;
   logic [31:0]   ram_wdata, ram_rdata;

   // request intake
   assign req_if.ready     = idle;
   assign start            = req_if.valid && idle;
   assign cmd.op           = req_if.op;
   assign cmd.request_size = req_if.request_size;
   assign cmd.block_offset = req_if.block_offset;

   // growth size register
   assign csr_if.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff <= CHUNK_RESET;
      end else if (csr_if.valid) begin
         chunk_ff <= csr_if.data;
      end
   end

   // output register
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= eng_rsp;
      end
   end
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.result_offset = rsp_ff.result_offset;
   assign rsp_if.status        = rsp_ff.status;

   sofla_engine #(
      .HEAP_BYTES (HEAP_BYTES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (cmd),
      .chunk     (chunk_ff),
      .out_free  (out_free),
      .idle      (idle),
      .done      (done),
      .rsp       (eng_rsp),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   sofla_heap_ram #(
      .DEPTH (HEAP_BYTES / 4)
   ) u_heap_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule
